/* design/rdq_pkg.sv */
// Shared types and constants for the reversible deque.
package rdq_pkg;

    localparam int DATA_W = 32;
    localparam int FUNC_W = 3;
    localparam int FILL_W = 5;
    localparam int ERR_W  = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH_BACK  = 3'd0,
        FUNC_PUSH_FRONT = 3'd1,
        FUNC_POP_BACK   = 3'd2,
        FUNC_POP_FRONT  = 3'd3,
        FUNC_REVERSE    = 3'd4,
        FUNC_PEEK       = 3'd5
    } t_func;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } t_err;

    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

endpackage

/* design/rdq_ifs.sv */
// Valid/ready channel interfaces for the deque operation and result streams.
interface rdq_in_if import rdq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, func, push_value, input ready);
    modport sink   (input valid, func, push_value, output ready);
endinterface

interface rdq_out_if import rdq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic                     is_empty;
    logic [FILL_W-1:0]        fill_count;
    logic [ERR_W-1:0]         error_code;

    modport source (output valid, front_value, back_value, is_empty, fill_count, error_code,
                    input ready);
    modport sink   (input valid, front_value, back_value, is_empty, fill_count, error_code,
                    output ready);
endinterface

/* design/rdq_ram.sv */
// Generic RAM: one write port and two read ports with registered read data.
module rdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

/* design/reversible_deque.sv */
// Top level of the reversible deque: ring store, end pointers and result pipeline.
//
//   channel   direction  payload                                             transfer
//   i_req     in         func, push_value                                    valid & ready
//   o_rsp     out        front_value, back_value, is_empty, fill_count,      valid & ready
//                        error_code
//
// One op per cycle while i_req.ready is high; results pass stage one and the output register.
// The pointers and count update at the operation's edge; the ring RAM reads the new
// head and tail slots in the next cycle, with a bypass for a slot written that cycle.
// Reset clears the pointers, count, reverse flag and valid bits; the RAM is not cleared.
// When the output register is full and not taken, one more result is held before
// i_req.ready drops.
module reversible_deque import rdq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rdq_in_if.sink     i_req,
    rdq_out_if.source  o_rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [AW-1:0] r_first, n_first;
    logic [CW-1:0] r_count, n_count;
    logic          r_rev, n_rev;

    logic          r_s1_valid;
    t_err          r_s1_err, n_err;

    logic                     r_byp_h, r_byp_t;
    logic signed [DATA_W-1:0] r_wval;

    logic                     r_o_valid;
    logic signed [DATA_W-1:0] r_o_front, r_o_back;
    logic                     r_o_empty;
    logic [FILL_W-1:0]        r_o_fill;
    t_err                     r_o_err;

    logic          accept, s1_move;
    logic          we;
    logic [AW-1:0] waddr, raddr_h, raddr_t;
    logic [AW-1:0] first_inc, first_dec, push_tail_slot;
    logic [SW-1:0] sum_p, sum_t;
    logic          at_tail_push, at_tail_pop;

    logic [DATA_W-1:0]        rdata_h, rdata_t;
    logic signed [DATA_W-1:0] head_val, tail_val;

    assign s1_move     = r_s1_valid && (!r_o_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s1_move;
    assign accept      = i_req.valid && i_req.ready;

    // Ring pointer arithmetic; DEPTH need not be a power of two.
    assign first_inc = (r_first == AW'(DEPTH - 1)) ? '0 : r_first + AW'(1);
    assign first_dec = (r_first == '0) ? AW'(DEPTH - 1) : r_first - AW'(1);
    assign sum_p     = SW'(r_first) + SW'(r_count);
    assign push_tail_slot = (sum_p >= SW'(DEPTH)) ? AW'(sum_p - SW'(DEPTH)) : AW'(sum_p);

    // A logical back operation hits the physical tail unless the deque is reversed.
    assign at_tail_push = (t_func'(i_req.func) == FUNC_PUSH_BACK) == !r_rev;
    assign at_tail_pop  = (t_func'(i_req.func) == FUNC_POP_BACK) == !r_rev;

    always_comb begin
        n_first = r_first;
        n_count = r_count;
        n_rev   = r_rev;
        n_err   = ERR_OK;
        we      = 1'b0;
        waddr   = push_tail_slot;
        if (accept) begin
            case (t_func'(i_req.func))
                FUNC_PUSH_BACK, FUNC_PUSH_FRONT: begin
                    if (r_count == CW'(DEPTH)) begin
                        n_err = ERR_FULL;
                    end else begin
                        we      = 1'b1;
                        n_count = r_count + CW'(1);
                        if (!at_tail_push) begin
                            waddr   = first_dec;
                            n_first = first_dec;
                        end
                    end
                end
                FUNC_POP_BACK, FUNC_POP_FRONT: begin
                    if (r_count == '0) begin
                        n_err = ERR_EMPTY;
                    end else begin
                        n_count = r_count - CW'(1);
                        if (!at_tail_pop) begin
                            n_first = first_inc;
                        end
                    end
                end
                FUNC_REVERSE: begin
                    n_rev = !r_rev;
                end
                default: begin
                    n_err = ERR_OK;
                end
            endcase
        end
    end

    // Read the head and tail of the state as it stands after this cycle.
    assign sum_t   = SW'(n_first) + SW'(n_count) - SW'(1);
    assign raddr_h = n_first;
    always_comb begin
        if (n_count == '0) begin
            raddr_t = n_first;
        end else if (sum_t >= SW'(DEPTH)) begin
            raddr_t = AW'(sum_t - SW'(DEPTH));
        end else begin
            raddr_t = AW'(sum_t);
        end
    end

    rdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (i_req.push_value),
        .i_raddr_a (raddr_h),
        .o_rdata_a (rdata_h),
        .i_raddr_b (raddr_t),
        .o_rdata_b (rdata_t)
    );

    // The RAM returns old data when a slot is read and written in the same cycle.
    always_ff @(posedge i_clk) begin
        r_wval  <= i_req.push_value;
        r_byp_h <= we && (waddr == raddr_h);
        r_byp_t <= we && (waddr == raddr_t);
    end

    assign head_val = r_byp_h ? r_wval : $signed(rdata_h);
    assign tail_val = r_byp_t ? r_wval : $signed(rdata_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first    <= '0;
            r_count    <= '0;
            r_rev      <= 1'b0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_first <= n_first;
            r_count <= n_count;
            r_rev   <= n_rev;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_err <= n_err;
        end
        // The state registers do not move while stage one waits, so they describe its item.
        if (s1_move) begin
            r_o_empty <= (r_count == '0);
            r_o_fill  <= FILL_W'(r_count);
            r_o_err   <= r_s1_err;
            if (r_count == '0) begin
                r_o_front <= EMPTY_VALUE;
                r_o_back  <= EMPTY_VALUE;
            end else begin
                r_o_front <= r_rev ? tail_val : head_val;
                r_o_back  <= r_rev ? head_val : tail_val;
            end
        end
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.front_value = r_o_front;
    assign o_rsp.back_value  = r_o_back;
    assign o_rsp.is_empty    = r_o_empty;
    assign o_rsp.fill_count  = r_o_fill;
    assign o_rsp.error_code  = r_o_err;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count above depth");

    a_first_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first <= AW'(DEPTH - 1))
        else $error("first slot outside the ring");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (r_count == CW'(DEPTH)) &&
        ((t_func'(i_req.func) == FUNC_PUSH_BACK) || (t_func'(i_req.func) == FUNC_PUSH_FRONT))
        |=> (r_s1_err == ERR_FULL) && $stable(r_count))
        else $error("push on full deque not dropped");

    a_state_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_count) && $stable(r_first) && $stable(r_rev))
        else $error("deque state moved without a transfer");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_o_valid && !o_rsp.ready |-> !i_req.ready)
        else $error("operation taken while both result stages are full");
`endif

endmodule

/* bench/tb.sv */
// Testbench for the reversible deque: directed and random operations checked against a shadow deque.
`timescale 1ns / 100ps

module tb;
    import rdq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 8;

    // Function codes the block treats like a peek.
    localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

    typedef struct {
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
        logic                     is_empty;
        logic [FILL_W-1:0]        fill_count;
        logic [ERR_W-1:0]         error_code;
    } t_deque_view;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rdq_in_if  req_if ();
    rdq_out_if rsp_if ();

    reversible_deque #(.DEPTH(DEPTH)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the deque contents.
    logic signed [DATA_W-1:0] shadow_slots [DEPTH];
    int                       shadow_head;
    int                       shadow_count;
    bit                       shadow_reversed;

    t_deque_view views_due[$];
    int          fail_count;
    int          cycle_count;
    bit          source_idle_en;
    bit          sink_idle_en;
    int          hold_request;

    function automatic t_deque_view step_shadow_deque(input logic [FUNC_W-1:0]        func,
                                                      input logic signed [DATA_W-1:0] value);
        t_deque_view view;
        bit          at_tail;
        view.error_code = ERR_OK;
        case (func)
            FUNC_PUSH_BACK, FUNC_PUSH_FRONT: begin
                if (shadow_count == DEPTH) begin
                    view.error_code = ERR_FULL;
                end else begin
                    at_tail = (func == FUNC_PUSH_BACK) == !shadow_reversed;
                    if (at_tail) begin
                        shadow_slots[(shadow_head + shadow_count) % DEPTH] = value;
                    end else begin
                        shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                        shadow_slots[shadow_head] = value;
                    end
                    shadow_count++;
                end
            end
            FUNC_POP_BACK, FUNC_POP_FRONT: begin
                if (shadow_count == 0) begin
                    view.error_code = ERR_EMPTY;
                end else begin
                    at_tail = (func == FUNC_POP_BACK) == !shadow_reversed;
                    if (!at_tail)
                        shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_count--;
                end
            end
            FUNC_REVERSE: shadow_reversed = !shadow_reversed;
            default: ;
        endcase
        view.front_value = EMPTY_VALUE;
        view.back_value  = EMPTY_VALUE;
        if (shadow_count != 0) begin
            view.front_value = shadow_reversed ?
                shadow_slots[(shadow_head + shadow_count - 1) % DEPTH] : shadow_slots[shadow_head];
            view.back_value  = shadow_reversed ?
                shadow_slots[shadow_head] : shadow_slots[(shadow_head + shadow_count - 1) % DEPTH];
        end
        view.is_empty   = (shadow_count == 0);
        view.fill_count = FILL_W'(shadow_count);
        return view;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Push share in percent steers the deque toward full or toward empty.
    function automatic logic [FUNC_W-1:0] pick_func(input int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return $urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
        if (r < 88)
            return $urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
        if (r < 94)
            return FUNC_REVERSE;
        case ($urandom_range(0, 2))
            0: return FUNC_PEEK;
            1: return FUNC_SPARE_6;
            default: return FUNC_SPARE_7;
        endcase
    endfunction

    // Offers one operation and waits for its transfer; valid stays high afterwards.
    task automatic send_op(input logic [FUNC_W-1:0] func, input logic signed [DATA_W-1:0] value);
        int gap;
        if (source_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.func       <= func;
        req_if.push_value <= value;
        do @(posedge i_clk); while (!req_if.ready);
        views_due.insert(views_due.size(), step_shadow_deque(func, value));
    endtask

    task automatic test_empty_ops();
        send_op(FUNC_POP_BACK, pick_value());
        send_op(FUNC_POP_FRONT, pick_value());
        send_op(FUNC_PEEK, $urandom);
        send_op(FUNC_SPARE_6, $urandom);
        send_op(FUNC_SPARE_7, $urandom);
        // The flag toggles even with nothing held, so pushes below run reversed.
        send_op(FUNC_REVERSE, $urandom);
    endtask

    task automatic test_fill_to_full();
        send_op(FUNC_PUSH_BACK, 32'sh7FFF_FFFF);
        send_op(FUNC_PUSH_FRONT, 32'sh8000_0000);
        for (int i = 2; i < DEPTH; i++)
            send_op((i % 2) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK, pick_value());
        send_op(FUNC_PUSH_BACK, pick_value());
        send_op(FUNC_PUSH_FRONT, pick_value());
        send_op(FUNC_REVERSE, $urandom);
        send_op(FUNC_POP_BACK, $urandom);
        send_op(FUNC_POP_FRONT, $urandom);
    endtask

    task automatic test_random_walk(input int count);
        int push_pct;
        for (int i = 0; i < count; i++) begin
            case ((i / 60) % 3)
                0: push_pct = 72;
                1: push_pct = 44;
                default: push_pct = 18;
            endcase
            send_op(pick_func(push_pct), pick_value());
        end
    endtask

    // The receiver holds off while operations keep coming, so the block backs up its input.
    task automatic test_backpressure();
        source_idle_en = 1'b0;
        hold_request   = 90;
        for (int i = 0; i < 50; i++)
            send_op(pick_func(50), pick_value());
    endtask

    // Result ready with random stalls and an occasional long hold-off.
    initial begin : rsp_ready_driver
        int hold;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold         = hold_request;
                hold_request = 0;
                rsp_if.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
                rsp_if.ready <= 1'b1;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 13);
                rsp_if.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
                rsp_if.ready <= 1'b1;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_deque_view want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (views_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("ERROR: unexpected result front=%0d back=%0d empty=%0b fill=%0d err=%0d",
                             rsp_if.front_value, rsp_if.back_value, rsp_if.is_empty,
                             rsp_if.fill_count, rsp_if.error_code);
            end else begin
                want = views_due[0];
                views_due.delete(0);
                if (rsp_if.front_value !== want.front_value || rsp_if.back_value !== want.back_value
                    || rsp_if.is_empty !== want.is_empty || rsp_if.fill_count !== want.fill_count
                    || rsp_if.error_code !== want.error_code) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"ERROR: mismatch expected front=%0d back=%0d empty=%0b fill=%0d ",
                                  "err=%0d, got front=%0d back=%0d empty=%0b fill=%0d err=%0d"},
                                 want.front_value, want.back_value, want.is_empty,
                                 want.fill_count, want.error_code,
                                 rsp_if.front_value, rsp_if.back_value, rsp_if.is_empty,
                                 rsp_if.fill_count, rsp_if.error_code);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        fail_count      = 0;
        cycle_count     = 0;
        hold_request    = 0;
        source_idle_en  = 1'b0;
        sink_idle_en    = 1'b0;
        shadow_head     = 0;
        shadow_count    = 0;
        shadow_reversed = 1'b0;
        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.func       <= FUNC_PEEK;
        req_if.push_value <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_ops();
        test_fill_to_full();
        source_idle_en = 1'b1;
        sink_idle_en   = 1'b1;
        test_random_walk(1400);
        test_backpressure();
        source_idle_en = 1'b0;
        sink_idle_en   = 1'b0;
        test_random_walk(550);
        req_if.valid <= 1'b0;

        while (views_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && views_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
design/rdq_pkg.sv
design/rdq_ifs.sv
design/rdq_ram.sv
design/reversible_deque.sv
bench/tb.sv
